// File: hdl/bcpr_pkg.sv
// Shared constants, types and the microcode table of the binomial coefficient core.
package bcpr_pkg;

  localparam int MAX_N     = 64;
  localparam int ROW_DEPTH = MAX_N + 1;
  localparam int IDX_W     = $clog2(ROW_DEPTH);
  localparam int N_W       = 7;
  localparam int COEF_W    = 61;
  localparam int UPC_W     = 3;

  typedef logic [N_W-1:0]    arg_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [UPC_W-1:0]  upc_t;

  // microcode addresses
  localparam upc_t UA_IDLE  = upc_t'(0);
  localparam upc_t UA_INIT  = upc_t'(1);
  localparam upc_t UA_SETUP = upc_t'(2);
  localparam upc_t UA_STEP  = upc_t'(3);
  localparam upc_t UA_NEXTI = upc_t'(4);
  localparam upc_t UA_READK = upc_t'(5);
  localparam upc_t UA_EMIT  = upc_t'(6);

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_N_ZERO,
    COND_J_GT1,
    COND_I_LT_N,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {
    RSEL_NONE,
    RSEL_I_M1,
    RSEL_J_M2,
    RSEL_K
  } rsel_t;

  typedef struct packed {
    logic  in_rdy;
    logic  we;
    logic  wr_one;
    logic  ld_i;
    logic  inc_i;
    logic  ld_j;
    logic  step_j;
    rsel_t rsel;
    logic  ld_out;
    cond_t cond;
    upc_t  tgt_t;
    upc_t  tgt_f;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    upc_t   step;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic n_zero;
    logic j_gt1;
    logic i_lt_n;
    logic out_free;
  } stat_t;

  // Control store: one word per step.
  function automatic uword_t urom(upc_t addr);
    uword_t w;
    w       = '0;
    w.rsel  = RSEL_NONE;
    w.cond  = COND_ALWAYS;
    w.tgt_t = UA_IDLE;
    w.tgt_f = UA_IDLE;
    case (addr)
      UA_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = COND_IN_VALID;
        w.tgt_t  = UA_INIT;
        w.tgt_f  = UA_IDLE;
      end
      UA_INIT: begin
        w.we     = 1'b1;
        w.wr_one = 1'b1;
        w.ld_i   = 1'b1;
        w.cond   = COND_N_ZERO;
        w.tgt_t  = UA_READK;
        w.tgt_f  = UA_SETUP;
      end
      UA_SETUP: begin
        w.ld_j  = 1'b1;
        w.rsel  = RSEL_I_M1;
        w.tgt_t = UA_STEP;
      end
      UA_STEP: begin
        w.we     = 1'b1;
        w.step_j = 1'b1;
        w.rsel   = RSEL_J_M2;
        w.cond   = COND_J_GT1;
        w.tgt_t  = UA_STEP;
        w.tgt_f  = UA_NEXTI;
      end
      UA_NEXTI: begin
        w.inc_i = 1'b1;
        w.cond  = COND_I_LT_N;
        w.tgt_t = UA_SETUP;
        w.tgt_f = UA_READK;
      end
      UA_READK: begin
        w.rsel  = RSEL_K;
        w.tgt_t = UA_EMIT;
      end
      UA_EMIT: begin
        // keep entry k on the read port while the result register is busy
        w.ld_out = 1'b1;
        w.rsel   = RSEL_K;
        w.cond   = COND_OUT_FREE;
        w.tgt_t  = UA_IDLE;
        w.tgt_f  = UA_EMIT;
      end
      default: begin
        w.tgt_t = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hdl/bcpr_in_if.sv
// Request channel: n and k with valid/ready.
interface bcpr_in_if;
  import bcpr_pkg::*;
  logic valid;
  logic ready;
  arg_t n;
  arg_t k;
  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

// File: hdl/bcpr_out_if.sv
// Result channel: binomial coefficient with valid/ready.
interface bcpr_out_if;
  import bcpr_pkg::*;
  logic  valid;
  logic  ready;
  coef_t coefficient;
  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

// File: hdl/bcpr_useq.sv
// Microcode sequencer: step counter, control store lookup and branch test.
module bcpr_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  bcpr_pkg::stat_t stat,
  output bcpr_pkg::ctrl_t ctrl
);
  import bcpr_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  uword_t uw;
  logic   take;

  assign uw = urom(upc_r);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_IN_VALID: take = stat.in_valid;
      COND_N_ZERO:   take = stat.n_zero;
      COND_J_GT1:    take = stat.j_gt1;
      COND_I_LT_N:   take = stat.i_lt_n;
      COND_OUT_FREE: take = stat.out_free;
      default:       take = 1'b1;
    endcase
    upc_nxt = take ? uw.tgt_t : uw.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl.uw   = uw;
  assign ctrl.step = upc_r;

endmodule

// File: hdl/bcpr_dpath.sv
// Datapath: Pascal row memory, shared adder, loop indexes and result register.
module bcpr_dpath (
  input  logic            clk,
  input  logic            rst_n,
  input  bcpr_pkg::ctrl_t ctrl,
  output bcpr_pkg::stat_t stat,
  input  logic            in_valid,
  input  bcpr_pkg::arg_t  in_n,
  input  bcpr_pkg::arg_t  in_k,
  input  logic            out_ready,
  output logic            out_valid,
  output bcpr_pkg::coef_t out_coef
);
  import bcpr_pkg::*;

  coef_t row_mem [ROW_DEPTH];

  idx_t  n_r;
  arg_t  k_r;
  logic  kbig_r;
  idx_t  i_r;
  idx_t  j_r;
  coef_t cur_r;
  coef_t rd_r;
  logic  out_valid_r;
  coef_t out_coef_r;

  arg_t  n_lim;
  idx_t  raddr;
  idx_t  waddr;
  coef_t wdata;
  logic  accept;
  logic  out_free;

  assign accept   = ctrl.uw.in_rdy & in_valid;
  assign out_free = ~out_valid_r | out_ready;
  assign n_lim    = (in_n > arg_t'(MAX_N)) ? arg_t'(MAX_N) : in_n;

  always_comb begin
    case (ctrl.uw.rsel)
      RSEL_I_M1: raddr = i_r - idx_t'(1);
      RSEL_J_M2: raddr = (j_r > idx_t'(1)) ? j_r - idx_t'(2) : '0;
      RSEL_K:    raddr = kbig_r ? '0 : idx_t'(k_r);
      RSEL_NONE: raddr = '0;
      default:   raddr = '0;
    endcase
  end

  // row[j] = old row[j] (held in cur) + old row[j-1] (just read)
  assign waddr = ctrl.uw.wr_one ? '0 : j_r;
  assign wdata = ctrl.uw.wr_one ? coef_t'(1) : cur_r + rd_r;

  always_ff @(posedge clk) begin
    if (ctrl.uw.we) begin
      row_mem[waddr] <= wdata;
    end
    rd_r <= row_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_r    <= idx_t'(n_lim);
      k_r    <= in_k;
      kbig_r <= in_k > n_lim;
    end
    if (ctrl.uw.ld_i) begin
      i_r <= idx_t'(1);
    end else if (ctrl.uw.inc_i) begin
      i_r <= i_r + idx_t'(1);
    end
    if (ctrl.uw.ld_j) begin
      j_r   <= i_r;
      cur_r <= '0;
    end else if (ctrl.uw.step_j) begin
      j_r   <= j_r - idx_t'(1);
      cur_r <= rd_r;
    end
    if (ctrl.uw.ld_out && out_free) begin
      out_coef_r <= kbig_r ? '0 : rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.uw.ld_out && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_coef      = out_coef_r;
  assign stat.in_valid = in_valid;
  assign stat.n_zero   = (n_r == '0);
  assign stat.j_gt1    = (j_r > idx_t'(1));
  assign stat.i_lt_n   = (i_r < n_r);
  assign stat.out_free = out_free;

endmodule

// File: hdl/binomial_coefficient_pascal_row_core.sv
// Top level: binomial coefficient C(n,k) built from one Pascal-triangle row.
// A request's n is saturated to MAX_N. Only one request is in work at a time: a new one
// is taken only after the result of the last has been loaded into the result register.
// One row entry is updated per cycle (one memory port pair, one adder), plus setup and
// index steps for each row; a stalled result holds the core in its emit step.
// Reset (rst_n, synchronous, active low) idles the sequencer and drops the result beat.
module binomial_coefficient_pascal_row_core (
  input  logic     clk,
  input  logic     rst_n,
  bcpr_in_if.sink    in_ch,
  bcpr_out_if.source out_ch
);
  import bcpr_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer walks the control store; the word at the current step drives the datapath.
  bcpr_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Datapath: row[j] += row[j-1] sweeping j downward, then read entry k.
  bcpr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_valid  (in_ch.valid),
    .in_n      (in_ch.n),
    .in_k      (in_ch.k),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_coef  (out_ch.coefficient)
  );

  // Take a request beat only in the idle step.
  assign in_ch.ready = ctrl.uw.in_rdy;

  // An accepted beat always starts the row build.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> ctrl.step == UA_INIT)
    else $error("accepted request did not enter init step");

  // A new result beat appears only from the emit step.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctrl.step) == UA_EMIT)
    else $error("result beat raised outside emit step");

  // Emit with a free output register must show a result next cycle.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step == UA_EMIT && stat.out_free |=> out_ch.valid)
    else $error("emit step did not present a result");

  // Row updates run only inside the row sweep or the row-0 init.
  a_write_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.uw.we |-> ctrl.step == UA_STEP || ctrl.step == UA_INIT)
    else $error("row memory written outside sweep");

endmodule
